/* design/pfru_pkg.sv */
package pfru_pkg;

   localparam int MAX_FRAMES = 32;
   localparam int FRAME_W    = 5;
   localparam int CNT_W      = 6;
   localparam int RND_W      = 31;
   localparam int TIME_W     = 32;
   localparam int WIN_W      = 16;
   localparam int CMD_W      = 2;
   localparam int POL_W      = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FAULT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

   localparam logic [POL_W-1:0] POL_FIFO   = 3'd0;
   localparam logic [POL_W-1:0] POL_RANDOM = 3'd1;
   localparam logic [POL_W-1:0] POL_CLOCK  = 3'd2;
   localparam logic [POL_W-1:0] POL_NRU    = 3'd3;
   localparam logic [POL_W-1:0] POL_AGING  = 3'd4;
   localparam logic [POL_W-1:0] POL_WSET   = 3'd5;

   localparam logic [1:0] CSR_POLICY    = 2'd0;
   localparam logic [1:0] CSR_FRAMES    = 2'd1;
   localparam logic [1:0] CSR_NRU_INT   = 2'd2;
   localparam logic [1:0] CSR_WS_WINDOW = 2'd3;

   localparam logic [POL_W-1:0]  POLICY_RESET   = POL_FIFO;
   localparam logic [CNT_W-1:0]  FRAMES_RESET   = 6'd32;
   localparam logic [WIN_W-1:0]  INTERVAL_RESET = 16'd50;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_ACCESS,
      DP_RELEASE,
      DP_NOP,
      DP_WAIT,
      DP_FQ_TAKE,
      DP_VICTIM_INIT,
      DP_FIFO_PICK,
      DP_RAND_STEP,
      DP_CLOCK_STEP,
      DP_NRU_STEP,
      DP_NRU_PICK,
      DP_AGE_STEP,
      DP_WS_STEP,
      DP_MAP
   } dp_op_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [POL_W-1:0] policy;
      logic             free_avail;
      logic             found;
      logic             last;
   } dp_status_type;

   function automatic logic [FRAME_W-1:0] next_of(input logic [FRAME_W-1:0] h,
                                                  input logic [CNT_W-1:0] n);
      next_of = (({1'b0, h} + CNT_W'(1)) >= n) ? '0 : h + FRAME_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] active_frames(input logic [CNT_W-1:0] v);
      if (v == '0) begin
         active_frames = CNT_W'(1);
      end else if (v > CNT_W'(MAX_FRAMES)) begin
         active_frames = CNT_W'(MAX_FRAMES);
      end else begin
         active_frames = v;
      end
   endfunction

endpackage

/* design/pfru_ctrl.sv */
module pfru_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  pfru_pkg::dp_status_type status,
   output pfru_pkg::dp_op_type     op
);
   import pfru_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FQ_TAKE,
      S_FIFO,
      S_RAND,
      S_CLOCK,
      S_NRU,
      S_NRU_PICK,
      S_AGE_RD,
      S_AGE_EXE,
      S_WS_RD,
      S_WS_EXE,
      S_MAP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op           = DP_IDLE;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = DP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.cmd)
               CMD_FAULT: begin
                  if (status.free_avail) begin
                     op       = DP_WAIT;
                     state_in = S_FQ_TAKE;
                  end else begin
                     op = DP_VICTIM_INIT;
                     unique case (status.policy)
                        POL_RANDOM: state_in = S_RAND;
                        POL_CLOCK:  state_in = S_CLOCK;
                        POL_NRU:    state_in = S_NRU;
                        POL_AGING:  state_in = S_AGE_RD;
                        POL_WSET:   state_in = S_WS_RD;
                        default:    state_in = S_FIFO;
                     endcase
                  end
               end
               CMD_ACCESS: begin
                  if (out_free) begin
                     op           = DP_ACCESS;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               CMD_RELEASE: begin
                  if (out_free) begin
                     op           = DP_RELEASE;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               CMD_NOP: begin
                  if (out_free) begin
                     op           = DP_NOP;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_FQ_TAKE: begin
            op       = DP_FQ_TAKE;
            state_in = S_MAP;
         end
         S_FIFO: begin
            op       = DP_FIFO_PICK;
            state_in = S_MAP;
         end
         S_RAND: begin
            op = DP_RAND_STEP;
            if (status.last) state_in = S_MAP;
         end
         S_CLOCK: begin
            op = DP_CLOCK_STEP;
            if (status.found || status.last) state_in = S_MAP;
         end
         S_NRU: begin
            op = DP_NRU_STEP;
            if (status.found) begin
               state_in = S_MAP;
            end else if (status.last) begin
               state_in = S_NRU_PICK;
            end
         end
         S_NRU_PICK: begin
            op       = DP_NRU_PICK;
            state_in = S_MAP;
         end
         S_AGE_RD: begin
            op       = DP_WAIT;
            state_in = S_AGE_EXE;
         end
         S_AGE_EXE: begin
            op       = DP_AGE_STEP;
            state_in = status.last ? S_MAP : S_AGE_RD;
         end
         S_WS_RD: begin
            op       = DP_WAIT;
            state_in = S_WS_EXE;
         end
         S_WS_EXE: begin
            op       = DP_WS_STEP;
            state_in = (status.found || status.last) ? S_MAP : S_WS_RD;
         end
         S_MAP: begin
            if (out_free) begin
               op           = DP_MAP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/pfru_datapath.sv */
module pfru_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [pfru_pkg::WIN_W-1:0]          csr_wdata,
   input  logic [pfru_pkg::CMD_W-1:0]          in_command,
   input  logic [pfru_pkg::FRAME_W-1:0]        in_frame_index,
   input  logic                                in_is_write,
   input  logic                                in_wr_prot,
   input  logic [pfru_pkg::TIME_W-1:0]         in_now,
   input  logic [pfru_pkg::RND_W-1:0]          in_random_value,
   input  pfru_pkg::dp_op_type                 op,
   output pfru_pkg::dp_status_type             status,
   output logic [pfru_pkg::RSP_DATA_W-1:0]     rsp_data
);
   import pfru_pkg::*;

   logic [POL_W-1:0]      policy_ff, policy_in;
   logic [CNT_W-1:0]      fiu_ff, fiu_in;
   logic [WIN_W-1:0]      nru_int_ff, nru_int_in;
   logic [WIN_W-1:0]      ws_win_ff, ws_win_in;

   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [FRAME_W-1:0]    idx_ff, idx_in;
   logic                  wr_ff, wr_in;
   logic                  prot_ff, prot_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [RND_W-1:0]      rnd_ff, rnd_in;

   logic [MAX_FRAMES-1:0] mapped_ff, mapped_in;
   logic [MAX_FRAMES-1:0] ref_ff, ref_in;
   logic [MAX_FRAMES-1:0] mod_ff, mod_in;
   logic [MAX_FRAMES-1:0] age_vld_ff, age_vld_in;
   logic [MAX_FRAMES-1:0] lu_vld_ff, lu_vld_in;
   logic [MAX_FRAMES-1:0] fq_vld_ff, fq_vld_in;

   logic [CNT_W-1:0]      free_count_ff, free_count_in;
   logic [FRAME_W-1:0]    free_head_ff, free_head_in;
   logic [FRAME_W-1:0]    hand_ff, hand_in;
   logic [TIME_W-1:0]     mark_ff, mark_in;

   logic [FRAME_W-1:0]    h_ff, h_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [FRAME_W-1:0]    best_ff, best_in;
   logic [TIME_W-1:0]     best_val_ff, best_val_in;
   logic                  sweep_ff, sweep_in;
   logic [3:0]            cls_v_ff, cls_v_in;
   logic [3:0][FRAME_W-1:0] cls_i_ff, cls_i_in;
   logic [FRAME_W-1:0]    rem_ff, rem_in;
   logic [FRAME_W-1:0]    f_ff, f_in;
   logic                  from_free_ff, from_free_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   logic [TIME_W-1:0]     age_mem [MAX_FRAMES];
   logic [TIME_W-1:0]     lu_mem [MAX_FRAMES];
   logic [FRAME_W-1:0]    fq_mem [MAX_FRAMES];
   logic [TIME_W-1:0]     age_rd_ff, lu_rd_ff;
   logic [FRAME_W-1:0]    fq_rd_ff;

   logic                  age_we, lu_we, fq_we;
   logic [FRAME_W-1:0]    age_wa, lu_wa, fq_wa;
   logic [TIME_W-1:0]     age_wd, lu_wd;
   logic [FRAME_W-1:0]    fq_wd;

   logic [CNT_W-1:0]      n;
   logic [FRAME_W-1:0]    nh, nnh, hs, pick, bsel, vsel;
   logic                  r_h, m_h;
   logic [1:0]            cls;
   logic                  found_clock, found_nru, found_ws;
   logic                  last_n, last_2n, last_rand;
   logic [TIME_W-1:0]     na, ws_age;
   logic [CNT_W-1:0]      r2, rm;
   logic                  acc_ok, rel_ok, was, vm;

   assign n    = active_frames(fiu_ff);
   assign nh   = next_of(h_ff, n);
   assign nnh  = next_of(nh, n);
   assign r_h  = ref_ff[h_ff];
   assign m_h  = mod_ff[h_ff];
   assign cls  = {r_h, m_h};
   assign na   = {r_h, age_rd_ff[TIME_W-1:1]};
   assign ws_age = now_ff - lu_rd_ff;

   assign found_clock = !r_h;
   assign found_nru   = (cls == 2'd0) && !sweep_ff && !cls_v_ff[0];
   assign found_ws    = !r_h && (ws_age >= {{(TIME_W-WIN_W){1'b0}}, ws_win_ff});

   assign last_n    = (k_ff == n - CNT_W'(1));
   assign last_2n   = ({1'b0, k_ff} == ({n, 1'b0} - (CNT_W+1)'(1)));
   assign last_rand = (k_ff == CNT_W'(RND_W - 1));

   assign r2 = {rem_ff, rnd_ff[FRAME_W'(RND_W - 1) - k_ff[FRAME_W-1:0]]};
   assign rm = (r2 >= n) ? r2 - n : r2;

   assign hs = ({1'b0, hand_ff} >= n) ? '0 : hand_ff;

   assign acc_ok = ({1'b0, idx_ff} < n) && mapped_ff[idx_ff];
   assign rel_ok = acc_ok && (free_count_ff < CNT_W'(MAX_FRAMES));
   assign was    = mapped_ff[f_ff];
   assign vm     = was & mod_ff[f_ff];

   always_comb begin
      if (cls_v_ff[0]) begin
         pick = cls_i_ff[0];
      end else if (cls_v_ff[1]) begin
         pick = cls_i_ff[1];
      end else if (cls_v_ff[2]) begin
         pick = cls_i_ff[2];
      end else if (cls_v_ff[3]) begin
         pick = cls_i_ff[3];
      end else begin
         pick = h_ff;
      end
   end

   assign bsel = ((k_ff == '0) || (na < best_val_ff)) ? h_ff : best_ff;
   assign vsel = (!r_h && ((k_ff == '0) || (lu_rd_ff < best_val_ff))) ? h_ff : best_ff;

   always_comb begin
      status.cmd        = cmd_ff;
      status.policy     = policy_ff;
      status.free_avail = (free_count_ff != '0);
      status.found      = 1'b0;
      status.last       = last_n;
      unique case (op)
         DP_CLOCK_STEP: begin
            status.found = found_clock;
            status.last  = last_2n;
         end
         DP_NRU_STEP:  status.found = found_nru;
         DP_WS_STEP:   status.found = found_ws;
         DP_RAND_STEP: status.last  = last_rand;
         default: ;
      endcase
   end

   always_comb begin
      policy_in     = policy_ff;
      fiu_in        = fiu_ff;
      nru_int_in    = nru_int_ff;
      ws_win_in     = ws_win_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      prot_in       = prot_ff;
      now_in        = now_ff;
      rnd_in        = rnd_ff;
      mapped_in     = mapped_ff;
      ref_in        = ref_ff;
      mod_in        = mod_ff;
      age_vld_in    = age_vld_ff;
      lu_vld_in     = lu_vld_ff;
      fq_vld_in     = fq_vld_ff;
      free_count_in = free_count_ff;
      free_head_in  = free_head_ff;
      hand_in       = hand_ff;
      mark_in       = mark_ff;
      h_in          = h_ff;
      k_in          = k_ff;
      best_in       = best_ff;
      best_val_in   = best_val_ff;
      sweep_in      = sweep_ff;
      cls_v_in      = cls_v_ff;
      cls_i_in      = cls_i_ff;
      rem_in        = rem_ff;
      f_in          = f_ff;
      from_free_in  = from_free_ff;
      rsp_in        = rsp_ff;
      age_we        = 1'b0;
      age_wa        = h_ff;
      age_wd        = na;
      lu_we         = 1'b0;
      lu_wa         = h_ff;
      lu_wd         = now_ff;
      fq_we         = 1'b0;
      fq_wa         = free_head_ff + free_count_ff[FRAME_W-1:0];
      fq_wd         = idx_ff;

      unique case (op)
         DP_LOAD: begin
            cmd_in  = in_command;
            idx_in  = in_frame_index;
            wr_in   = in_is_write;
            prot_in = in_wr_prot;
            now_in  = in_now;
            rnd_in  = in_random_value;
         end
         DP_ACCESS: begin
            if (acc_ok) begin
               if (wr_ff && !prot_ff) mod_in[idx_ff] = 1'b1;
               ref_in[idx_ff] = 1'b1;
            end
            rsp_in = {3'b000, idx_ff};
         end
         DP_RELEASE: begin
            if (rel_ok) begin
               mapped_in[idx_ff] = 1'b0;
               ref_in[idx_ff]    = 1'b0;
               mod_in[idx_ff]    = 1'b0;
               fq_we             = 1'b1;
               fq_vld_in[fq_wa]  = 1'b1;
               free_count_in     = free_count_ff + CNT_W'(1);
            end
            rsp_in = {rel_ok & mod_ff[idx_ff], 2'b00, idx_ff};
         end
         DP_NOP: begin
            rsp_in = {3'b000, idx_ff};
         end
         DP_FQ_TAKE: begin
            f_in          = ({1'b0, fq_rd_ff} >= n) ? '0 : fq_rd_ff;
            free_head_in  = free_head_ff + FRAME_W'(1);
            free_count_in = free_count_ff - CNT_W'(1);
            from_free_in  = 1'b1;
         end
         DP_VICTIM_INIT: begin
            hand_in      = hs;
            h_in         = hs;
            best_in      = hs;
            k_in         = '0;
            cls_v_in     = '0;
            rem_in       = '0;
            from_free_in = 1'b0;
            sweep_in     = 1'b0;
            if ((policy_ff == POL_NRU) &&
                ((now_ff - mark_ff) >= {{(TIME_W-WIN_W){1'b0}}, nru_int_ff})) begin
               sweep_in = 1'b1;
               mark_in  = now_ff;
            end
         end
         DP_FIFO_PICK: begin
            f_in    = h_ff;
            hand_in = nh;
         end
         DP_RAND_STEP: begin
            rem_in = rm[FRAME_W-1:0];
            f_in   = rm[FRAME_W-1:0];
            k_in   = k_ff + CNT_W'(1);
         end
         DP_CLOCK_STEP: begin
            if (found_clock) begin
               f_in    = h_ff;
               hand_in = nh;
            end else begin
               ref_in[h_ff] = 1'b0;
               h_in         = nh;
               k_in         = k_ff + CNT_W'(1);
               f_in         = nh;
               hand_in      = nnh;
            end
         end
         DP_NRU_STEP: begin
            if (found_nru) begin
               f_in    = h_ff;
               hand_in = nh;
            end else begin
               if (!cls_v_ff[cls]) begin
                  cls_v_in[cls] = 1'b1;
                  cls_i_in[cls] = h_ff;
               end
               if (sweep_ff) ref_in[h_ff] = 1'b0;
               h_in = nh;
               k_in = k_ff + CNT_W'(1);
            end
         end
         DP_NRU_PICK: begin
            f_in    = pick;
            hand_in = next_of(pick, n);
         end
         DP_AGE_STEP: begin
            age_we             = 1'b1;
            age_vld_in[h_ff]   = 1'b1;
            ref_in[h_ff]       = 1'b0;
            best_in            = bsel;
            if (bsel == h_ff) best_val_in = na;
            f_in               = bsel;
            hand_in            = next_of(bsel, n);
            h_in               = nh;
            k_in               = k_ff + CNT_W'(1);
         end
         DP_WS_STEP: begin
            if (r_h) begin
               lu_we           = 1'b1;
               lu_vld_in[h_ff] = 1'b1;
               ref_in[h_ff]    = 1'b0;
               if (k_ff == '0) best_val_in = now_ff;
            end
            if (found_ws) begin
               f_in    = h_ff;
               hand_in = nh;
            end else begin
               best_in = vsel;
               if (!r_h && (vsel == h_ff)) best_val_in = lu_rd_ff;
               f_in    = vsel;
               hand_in = next_of(vsel, n);
               h_in    = nh;
               k_in    = k_ff + CNT_W'(1);
            end
         end
         DP_MAP: begin
            mapped_in[f_ff] = 1'b1;
            mod_in[f_ff]    = (wr_ff && !prot_ff) || (mod_ff[f_ff] && !was);
            ref_in[f_ff]    = 1'b1;
            if (policy_ff == POL_AGING) begin
               age_we           = 1'b1;
               age_wa           = f_ff;
               age_wd           = '0;
               age_vld_in[f_ff] = 1'b1;
            end
            lu_we           = 1'b1;
            lu_wa           = f_ff;
            lu_vld_in[f_ff] = 1'b1;
            rsp_in          = {vm, was, from_free_ff, f_ff};
         end
         default: ;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:    policy_in  = csr_wdata[POL_W-1:0];
            CSR_FRAMES: begin
               fiu_in        = csr_wdata[CNT_W-1:0];
               mapped_in     = '0;
               ref_in        = '0;
               mod_in        = '0;
               age_vld_in    = '0;
               lu_vld_in     = '0;
               fq_vld_in     = '0;
               free_count_in = active_frames(csr_wdata[CNT_W-1:0]);
               free_head_in  = '0;
               hand_in       = '0;
               mark_in       = '0;
            end
            CSR_NRU_INT:   nru_int_in = csr_wdata;
            CSR_WS_WINDOW: ws_win_in  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_RESET;
         fiu_ff        <= FRAMES_RESET;
         nru_int_ff    <= INTERVAL_RESET;
         ws_win_ff     <= INTERVAL_RESET;
         mapped_ff     <= '0;
         ref_ff        <= '0;
         mod_ff        <= '0;
         age_vld_ff    <= '0;
         lu_vld_ff     <= '0;
         fq_vld_ff     <= '0;
         free_count_ff <= active_frames(FRAMES_RESET);
         free_head_ff  <= '0;
         hand_ff       <= '0;
         mark_ff       <= '0;
      end else begin
         policy_ff     <= policy_in;
         fiu_ff        <= fiu_in;
         nru_int_ff    <= nru_int_in;
         ws_win_ff     <= ws_win_in;
         mapped_ff     <= mapped_in;
         ref_ff        <= ref_in;
         mod_ff        <= mod_in;
         age_vld_ff    <= age_vld_in;
         lu_vld_ff     <= lu_vld_in;
         fq_vld_ff     <= fq_vld_in;
         free_count_ff <= free_count_in;
         free_head_ff  <= free_head_in;
         hand_ff       <= hand_in;
         mark_ff       <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      wr_ff        <= wr_in;
      prot_ff      <= prot_in;
      now_ff       <= now_in;
      rnd_ff       <= rnd_in;
      h_ff         <= h_in;
      k_ff         <= k_in;
      best_ff      <= best_in;
      best_val_ff  <= best_val_in;
      sweep_ff     <= sweep_in;
      cls_v_ff     <= cls_v_in;
      cls_i_ff     <= cls_i_in;
      rem_ff       <= rem_in;
      f_ff         <= f_in;
      from_free_ff <= from_free_in;
      rsp_ff       <= rsp_in;
   end

   // per-frame tables, read data registered; unwritten entries read as zero, free queue entries as their own index
   always_ff @(posedge clock) begin
      if (age_we) age_mem[age_wa] <= age_wd;
      age_rd_ff <= age_vld_ff[h_ff] ? age_mem[h_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (lu_we) lu_mem[lu_wa] <= lu_wd;
      lu_rd_ff <= lu_vld_ff[h_ff] ? lu_mem[h_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (fq_we) fq_mem[fq_wa] <= fq_wd;
      fq_rd_ff <= fq_vld_ff[free_head_ff] ? fq_mem[free_head_ff] : free_head_ff;
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/page_frame_replacement_unit.sv */
// page frame replacement unit
// req channel: one command per transfer (access, fault, release, nop); the block
//   takes a new request only when the previous one has left the datapath
// rsp channel: exactly one result per request, held in an output register
// csr port: policy, frame count, nru interval, working set window; writing
//   the frame count reinitializes the frame table and free queue; the user must
//   do it only while no request is in flight, the block does not enforce this
// steps from request transfer to result valid:
//   access, release, nop: answered from the decode state
//   fault served from the free queue or fifo victim: decode, then a pick state, then map
//   random victim: the bit-serial remainder unit walks every bit of random_value
//   clock and nru victim: one frame per cycle
//   aging and working set victim: a read state and a step state per frame
//     for the registered read of the age or last-use table
// a new request is accepted in the cycle after the result is produced, even
//   if that result has not been taken; a stalled rsp side holds the block
//   once its next result is ready
// reset restores the register defaults and the full free queue at once
module page_frame_replacement_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // frame_index, is_write, wr_prot, now, random_value, zero fill
   input  logic [pfru_pkg::REQ_DATA_W-1:0]       req_tdata,
   // command
   input  logic [pfru_pkg::CMD_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // chosen_frame, from_free_list, evicted, victim_modified
   output logic [pfru_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [pfru_pkg::WIN_W-1:0]            csr_wdata
);
   import pfru_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   pfru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .op         (op)
   );

   pfru_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .in_command         (req_tuser),
      .in_frame_index     (req_tdata[4:0]),
      .in_is_write        (req_tdata[5]),
      .in_wr_prot         (req_tdata[6]),
      .in_now             (req_tdata[38:7]),
      .in_random_value    (req_tdata[69:39]),
      .op                 (op),
      .status             (status),
      .rsp_data           (rsp_tdata)
   );

endmodule

/* design/pfru_checker.sv */
module pfru_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [pfru_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // a result waiting on the rsp side stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp dropped while stalled");

   // no result is offered right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // one request at a time: busy in the cycle after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a result is never flagged as both served from the free queue and an eviction
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[5] && rsp_tdata[6]))
      else $error("free queue and eviction both flagged");

endmodule

bind page_frame_replacement_unit pfru_checker u_pfru_checker (.*);

/* test/tb_page_frame_replacement_unit.sv */
`timescale 1ns / 100ps

module tb_page_frame_replacement_unit;
   import pfru_pkg::*;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [FRAME_W-1:0] idx;
      logic               wr;
      logic               prot;
      logic [TIME_W-1:0]  now;
      logic [RND_W-1:0]   rnd;
   } page_cmd_type;

   // packed from the top bit down, so frame lands in the low bits
   typedef struct packed {
      logic               vmod;
      logic               evicted;
      logic               from_free;
      logic [FRAME_W-1:0] frame;
   } page_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [WIN_W-1:0] csr_wdata = '0;

   page_frame_replacement_unit i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // frame table copy
   logic [POL_W-1:0] m_policy;
   logic [CNT_W-1:0] m_frames;
   logic [WIN_W-1:0] m_nru_int, m_window;
   logic m_mapped [MAX_FRAMES];
   logic m_ref [MAX_FRAMES];
   logic m_mod [MAX_FRAMES];
   logic [31:0] m_age [MAX_FRAMES];
   logic [31:0] m_last [MAX_FRAMES];
   logic [FRAME_W-1:0] m_fq [MAX_FRAMES];
   int m_free_cnt, m_free_head, m_hand;
   logic [31:0] m_sweep_mark;

   page_cmd_type pending_cmds[$];
   page_rsp_type expected_rsps[$];
   int errors = 0;
   int idle_pct = 0, stall_pct = 0;
   int n_rsp = 0, n_faults = 0, n_evict = 0;

   function automatic int nframes();
      if (m_frames == 0) return 1;
      if (m_frames > MAX_FRAMES) return MAX_FRAMES;
      return m_frames;
   endfunction

   function automatic int nxt(int i, int n);
      return (i + 1 >= n) ? 0 : i + 1;
   endfunction

   function automatic void clear_table();
      int n;
      n = nframes();
      for (int i = 0; i < MAX_FRAMES; i++) begin
         m_mapped[i] = 0; m_ref[i] = 0; m_mod[i] = 0;
         m_age[i] = 0; m_last[i] = 0;
         m_fq[i] = (i < n) ? FRAME_W'(i) : '0;
      end
      m_free_cnt = n; m_free_head = 0; m_hand = 0; m_sweep_mark = 0;
   endfunction

   function automatic int pick_victim(int n, logic [31:0] now, logic [30:0] rnd);
      int h, k, best;
      int cls[4];
      logic sweep;
      logic [31:0] age;
      if (m_hand >= n) m_hand = 0;
      h = m_hand;
      case (m_policy)
         POL_RANDOM: return rnd % n;
         POL_CLOCK: begin
            for (k = 0; k < 2 * n; k++) begin
               if (!m_ref[h]) break;
               m_ref[h] = 0;
               h = nxt(h, n);
            end
            m_hand = nxt(h, n);
            return h;
         end
         POL_NRU: begin
            cls = '{-1, -1, -1, -1};
            sweep = 0;
            if (now - m_sweep_mark >= 32'(m_nru_int)) begin
               sweep = 1; m_sweep_mark = now;
            end
            for (k = 0; k < n; k++) begin
               best = 2 * m_ref[h] + m_mod[h];
               if (cls[best] < 0) begin
                  if (best == 0 && !sweep) begin
                     m_hand = nxt(h, n);
                     return h;
                  end
                  cls[best] = h;
               end
               if (sweep) m_ref[h] = 0;
               h = nxt(h, n);
            end
            for (k = 0; k < 4; k++)
               if (cls[k] >= 0) begin
                  h = cls[k];
                  break;
               end
            m_hand = nxt(h, n);
            return h;
         end
         POL_AGING: begin
            best = h;
            for (k = 0; k < n; k++) begin
               m_age[h] = m_age[h] >> 1;
               if (m_ref[h]) m_age[h][31] = 1;
               if (m_age[h] < m_age[best]) best = h;
               m_ref[h] = 0;
               h = nxt(h, n);
            end
            m_hand = nxt(best, n);
            return best;
         end
         POL_WSET: begin
            best = h;
            for (k = 0; k < n; k++) begin
               age = now - m_last[h];
               if (m_ref[h]) begin
                  m_last[h] = now; m_ref[h] = 0;
               end else if (age >= 32'(m_window)) begin
                  best = h;
                  break;
               end else if (m_last[h] < m_last[best]) begin
                  best = h;
               end
               h = nxt(h, n);
            end
            m_hand = nxt(best, n);
            return best;
         end
         default: begin
            m_hand = nxt(h, n);
            return h;
         end
      endcase
   endfunction

   function automatic page_rsp_type predict_page_rsp(page_cmd_type c);
      page_rsp_type r;
      int n, f;
      n = nframes();
      r = '{frame: c.idx, default: 0};
      case (c.cmd)
         CMD_ACCESS:
            if (c.idx < n && m_mapped[c.idx]) begin
               if (c.wr && !c.prot) m_mod[c.idx] = 1;
               m_ref[c.idx] = 1;
            end
         CMD_FAULT: begin
            if (m_free_cnt > 0) begin
               f = m_fq[m_free_head];
               if (f >= n) f = 0;
               m_free_head = (m_free_head + 1) % MAX_FRAMES;
               m_free_cnt--;
               r.from_free = 1;
            end else begin
               f = pick_victim(n, c.now, c.rnd);
               if (f >= n) f = 0;
            end
            if (m_mapped[f]) begin
               r.evicted = 1; r.vmod = m_mod[f];
               m_ref[f] = 0; m_mod[f] = 0;
            end
            m_mapped[f] = 1;
            if (m_policy == POL_AGING) m_age[f] = 0;
            m_last[f] = c.now;
            if (c.wr && !c.prot) m_mod[f] = 1;
            m_ref[f] = 1;
            r.frame = FRAME_W'(f);
         end
         CMD_RELEASE:
            if (c.idx < n && m_mapped[c.idx] && m_free_cnt < MAX_FRAMES) begin
               r.vmod = m_mod[c.idx];
               m_mapped[c.idx] = 0; m_ref[c.idx] = 0; m_mod[c.idx] = 0;
               m_fq[(m_free_head + m_free_cnt) % MAX_FRAMES] = c.idx;
               m_free_cnt++;
            end
         default: ;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      page_cmd_type c;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
               c = pending_cmds[0];
               pending_cmds.delete(0);
               req_tvalid <= 1;
               req_tuser <= c.cmd;
               req_tdata <= REQ_DATA_W'({c.rnd, c.now, c.prot, c.wr, c.idx});
               expected_rsps.insert(expected_rsps.size(), predict_page_rsp(c));
            end else begin
               req_tvalid <= 0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      page_rsp_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = page_rsp_type'(rsp_tdata[7:0]);
         n_rsp++;
         if (got.evicted) n_evict++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            exp_r = expected_rsps[0];
            expected_rsps.delete(0);
            if (got !== exp_r) begin
               $display("%0t: mismatch expected frame %0d free %0b evict %0b mod %0b,",
                  $time, exp_r.frame, exp_r.from_free, exp_r.evicted, exp_r.vmod);
               $display("   actual frame %0d free %0b evict %0b mod %0b",
                  got.frame, got.from_free, got.evicted, got.vmod);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [WIN_W-1:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_POLICY: m_policy = v[POL_W-1:0];
         CSR_FRAMES: begin
            m_frames = v[CNT_W-1:0];
            clear_table();
         end
         CSR_NRU_INT: m_nru_int = v;
         default: m_window = v;
      endcase
   endtask

   task automatic add_cmd(page_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   function automatic page_cmd_type rand_cmd(int n, logic [31:0] now);
      page_cmd_type c;
      int p;
      p = $urandom_range(99);
      c.cmd = (p < 45) ? CMD_ACCESS : (p < 80) ? CMD_FAULT :
              (p < 96) ? CMD_RELEASE : CMD_NOP;
      c.idx = ($urandom_range(9) == 0) ? FRAME_W'($urandom) : FRAME_W'($urandom_range(n - 1));
      c.wr = 1'($urandom); c.prot = 1'($urandom);
      c.now = ($urandom_range(30) == 0) ? $urandom : now;
      c.rnd = RND_W'($urandom);
      return c;
   endfunction

   initial begin
      page_cmd_type c;
      logic [31:0] now;
      int n;
      m_policy = POLICY_RESET; m_frames = FRAMES_RESET;
      m_nru_int = INTERVAL_RESET; m_window = INTERVAL_RESET;
      clear_table();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command, unknown codes
      csr_write(CSR_FRAMES, 16'd2);
      for (int i = 0; i < 4; i++)
         add_cmd(page_cmd_type'{CMD_FAULT, 5'd31, 1'b1, 1'b0, 32'hffff_ffff, 31'h7fff_ffff});
      add_cmd(page_cmd_type'{CMD_ACCESS, 5'd1, 1'b1, 1'b0, 32'd0, 31'd0});
      add_cmd(page_cmd_type'{CMD_ACCESS, 5'd31, 1'b1, 1'b1, 32'd0, 31'd0});
      add_cmd(page_cmd_type'{CMD_RELEASE, 5'd1, 1'b0, 1'b0, 32'd0, 31'd0});
      add_cmd(page_cmd_type'{CMD_RELEASE, 5'd1, 1'b0, 1'b0, 32'd0, 31'd0});
      add_cmd(page_cmd_type'{CMD_RELEASE, 5'd31, 1'b0, 1'b0, 32'd0, 31'd0});
      add_cmd(page_cmd_type'{CMD_NOP, 5'd17, 1'b1, 1'b1, 32'd5, 31'd5});
      wait_drained();
      csr_write(CSR_POLICY, 16'd7);
      csr_write(CSR_FRAMES, 16'd0);
      for (int i = 0; i < 3; i++)
         add_cmd(page_cmd_type'{CMD_FAULT, 5'd0, 1'b0, 1'b0, 32'd1, 31'd3});
      wait_drained();
      csr_write(CSR_POLICY, 16'd6);
      csr_write(CSR_FRAMES, 16'd63);
      csr_write(CSR_NRU_INT, 16'd0);
      csr_write(CSR_WS_WINDOW, 16'd0);
      wait_drained();

      // random phases over policies, sizes and idling patterns
      now = 0;
      for (int ph = 0; ph < 24; ph++) begin
         csr_write(CSR_POLICY, WIN_W'(ph % 6));
         n = (ph % 5 == 0) ? 32 : (ph % 5 == 1) ? 1 : $urandom_range(2, 12);
         csr_write(CSR_FRAMES, WIN_W'((ph == 7) ? 0 : n));
         csr_write(CSR_NRU_INT, WIN_W'((ph % 4 == 0) ? 16'hffff :
                                       (ph % 4 == 1) ? 0 : $urandom_range(1, 60)));
         csr_write(CSR_WS_WINDOW, WIN_W'((ph % 3 == 0) ? 16'hffff :
                                         (ph % 3 == 1) ? 0 : $urandom_range(1, 60)));
         n = nframes();
         case ((ph / 6) % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 47; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 47; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         for (int i = 0; i < 80; i++) begin
            now += $urandom_range(0, 20);
            c = rand_cmd(n, now);
            if (c.cmd == CMD_FAULT) n_faults++;
            add_cmd(c);
            if (i == 40) begin
               // hold off until the block has gone quiet
               while (pending_cmds.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
            end
         end
         wait_drained();
      end

      $display("covered %0d results, %0d faults, %0d evictions", n_rsp, n_faults, n_evict);
      $display("all six policies, frame counts 1 to 32 and interval extremes");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule

/* filelist.f */
design/pfru_pkg.sv
design/pfru_ctrl.sv
design/pfru_datapath.sv
design/page_frame_replacement_unit.sv
design/pfru_checker.sv
test/tb_page_frame_replacement_unit.sv
